[rtl/core/mapt_pkg.sv]
// ============================================================================
// mapt_pkg
// Shared constants and types for the access profile table.
// ============================================================================
package mapt_pkg;

  // Table geometry. TABLE_SLOTS must be a power of two (home slot and
  // wrap are taken from the low bits).
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned PROBE_LIMIT = 64;

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned PROBE_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int unsigned SLOT_INDEX_W = 10;

  localparam logic [31:0] HASH_MUL  = 32'd2654435761;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OUTCOME_HIT  = 2'd0,
    OUTCOME_NEW  = 2'd1,
    OUTCOME_DROP = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [31:0] access_address;
    logic [31:0] access_value;
    logic        is_write_access;
    logic [63:0] cycle_stamp;
  } req_t;

  typedef struct packed {
    outcome_e                  outcome;
    logic [SLOT_INDEX_W-1:0]   slot_index;
    logic [31:0]               updated_count;
  } rsp_t;

  // One slot of the lookup store.
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] rd_cnt;
    logic [31:0] wr_cnt;
  } entry_t;

  // Last value and cycle seen for one direction.
  typedef struct packed {
    logic [31:0] value;
    logic [63:0] cycle;
  } last_t;

  // Controller -> datapath.
  typedef struct packed {
    logic clear_step;
    logic load_req;
    logic hash;
    logic probe_init;
    logic probe_read;
    logic probe_next;
    logic commit;
    logic drop;
  } cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic clear_last;
    logic match;
    logic probe_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/mapt_req_if.sv]
// ============================================================================
// mapt_req_if
// Valid/ready channel carrying one observed bus access request.
// ============================================================================
interface mapt_req_if;
  import mapt_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[rtl/core/mapt_rsp_if.sv]
// ============================================================================
// mapt_rsp_if
// Valid/ready channel carrying one profile update result.
// ============================================================================
interface mapt_rsp_if;
  import mapt_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[rtl/core/mapt_ctrl.sv]
// ============================================================================
// mapt_ctrl
// Sequencer: clearing sweep, hash, probe loop, commit or drop.
// ============================================================================
module mapt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  mapt_pkg::sts_t sts_i,
  output mapt_pkg::cmd_t cmd_o
);
  import mapt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_START,
    S_READ,
    S_EVAL
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = S_START;
      end
      S_START: begin
        cmd_o.probe_init = 1'b1;
        state_d          = S_READ;
      end
      S_READ: begin
        cmd_o.probe_read = 1'b1;
        state_d          = S_EVAL;
      end
      S_EVAL: begin
        // on a match or the last probe, hold here while the result register is still occupied
        if (sts_i.match) begin
          if (sts_i.out_free) begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (sts_i.probe_last) begin
          if (sts_i.out_free) begin
            cmd_o.drop = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/mapt_dpath.sv]
// ============================================================================
// mapt_dpath
// Request registers, hash multiplier, probe pointer, slot stores, result reg.
// ============================================================================
module mapt_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mapt_pkg::cmd_t cmd_i,
  output mapt_pkg::sts_t sts_o,
  input  mapt_pkg::req_t req_data_i,
  input  logic           rsp_ready_i,
  output logic           rsp_valid_o,
  output mapt_pkg::rsp_t rsp_data_o
);
  import mapt_pkg::*;

  // slot stores
  entry_t entry_mem    [TABLE_SLOTS];
  last_t  rd_last_mem  [TABLE_SLOTS];
  last_t  wr_last_mem  [TABLE_SLOTS];

  req_t               req_q;
  logic [31:0]        prod_q;
  logic [SLOT_W-1:0]  ptr_q;
  logic [PROBE_W-1:0] pcnt_q;
  logic [SLOT_W-1:0]  clr_q;
  entry_t             rd_q;
  logic               out_valid_q;
  rsp_t               out_q;

  logic        empty;
  logic [31:0] cnt_sel;
  logic [31:0] cnt_new;
  entry_t      upd;
  logic        mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t      mem_wdata;

  // request and hash registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q  <= req_data_i;
    if (cmd_i.hash)     prod_q <= req_q.access_address * HASH_MUL;
  end

  // probe pointer wraps naturally at the table size
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_init) begin
      ptr_q  <= prod_q[SLOT_W-1:0];
      pcnt_q <= '0;
    end else if (cmd_i.probe_next) begin
      ptr_q  <= ptr_q + SLOT_W'(1);
      pcnt_q <= pcnt_q + PROBE_W'(1);
    end
  end

  // clearing sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + SLOT_W'(1);
    end
  end

  // slot evaluation
  assign empty   = (rd_q.rd_cnt == '0) && (rd_q.wr_cnt == '0);
  assign cnt_sel = req_q.is_write_access ? rd_q.wr_cnt : rd_q.rd_cnt;
  assign cnt_new = (cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + 32'd1;

  always_comb begin
    upd.addr   = req_q.access_address;
    upd.rd_cnt = req_q.is_write_access ? rd_q.rd_cnt : cnt_new;
    upd.wr_cnt = req_q.is_write_access ? cnt_new : rd_q.wr_cnt;
  end

  assign mem_we    = cmd_i.clear_step || cmd_i.commit;
  assign mem_waddr = cmd_i.clear_step ? clr_q : ptr_q;
  assign mem_wdata = cmd_i.clear_step ? '0 : upd;

  always_ff @(posedge clk_i) begin
    if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_read) rd_q <= entry_mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !req_q.is_write_access) begin
      rd_last_mem[ptr_q] <= {req_q.access_value, req_q.cycle_stamp};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && req_q.is_write_access) begin
      wr_last_mem[ptr_q] <= {req_q.access_value, req_q.cycle_stamp};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.drop) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.outcome       <= empty ? OUTCOME_NEW : OUTCOME_HIT;
      out_q.slot_index    <= SLOT_INDEX_W'(ptr_q);
      out_q.updated_count <= cnt_new;
    end else if (cmd_i.drop) begin
      out_q.outcome       <= OUTCOME_DROP;
      out_q.slot_index    <= '0;
      out_q.updated_count <= '0;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o  = out_q;

  assign sts_o.clear_last = (clr_q == {SLOT_W{1'b1}});
  assign sts_o.match      = empty || (rd_q.addr == req_q.access_address);
  assign sts_o.probe_last = (pcnt_q == PROBE_W'(PROBE_LIMIT - 1));
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

endmodule

[rtl/core/mmio_access_profile_table.sv]
// ============================================================================
// mmio_access_profile_table
// Bus-access profiler: per-address read/write counts in a linear-probed table.
// ============================================================================
//
//  channel | dir | payload                                              | handshake
//  --------+-----+------------------------------------------------------+----------
//  req_i   | in  | access_address, access_value, is_write_access,       | valid/ready
//          |     | cycle_stamp                                          |
//  rsp_o   | out | outcome, slot_index, updated_count                   | valid/ready
//
//  Sequence: one request at a time. A request whose first probe qualifies
//  has its result registered after the hash multiply, pointer load,
//  slot read and evaluate/commit steps; each further probe adds a
//  registered read of the slot store, then a compare, up to PROBE_LIMIT
//  probes in all. Ready returns at the edge that registers the result, so
//  a new request is not taken before the previous one is finished.
//  Reset: after rst_ni a clearing sweep zeroes all TABLE_SLOTS (1024) slot
//  counts, one slot per cycle; no request is accepted during the sweep.
//  Stalls: the result register lets a new request be accepted while the
//  previous result waits; a finished probe holds until that register frees.
//
module mmio_access_profile_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  mapt_req_if.sink          req_i,
  mapt_rsp_if.source        rsp_o
);
  import mapt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  // sequencer: clearing sweep, then hash -> probe loop -> commit or drop
  mapt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // request regs, multiplicative hash, slot stores and result register
  mapt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_data_i  (req_i.data),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_data_o  (rsp_o.data)
  );

  assign req_i.ready = req_ready;

endmodule
